### design/pid_pkg.sv
// Shared types and constants for the PID step block.
`default_nettype none
package pid_pkg;
    localparam int unsigned DIVERGE_TIME_MS = 1000;
    localparam int unsigned NUM_REGS        = 8;

    typedef enum logic [2:0] {
        REG_GAIN_PROP     = 3'd0,
        REG_GAIN_INTEG    = 3'd1,
        REG_GAIN_DERIV    = 3'd2,
        REG_INTEG_FLOOR   = 3'd3,
        REG_INTEG_CEILING = 3'd4,
        REG_DRIVE_FLOOR   = 3'd5,
        REG_DRIVE_CEILING = 3'd6,
        REG_ERROR_BAND    = 3'd7
    } reg_index_t;

    // Start request from the sequencer to the serial units.
    typedef struct packed {
        logic start;
    } unit_req_t;
endpackage
`default_nettype wire

### design/pid_step_antiwindup_divergence.sv
// PID step top level: sequencer, registers and state around serial mul/div units.
//
// Usage:
//   Input channel (target, sensed, elapsed_ms) is a valid/stall transfer;
//   in_stall stays high while a step is in progress or its result waits.
//   Output channel (drive, at_limit, diverging) presents one result per input;
//   out_valid holds with a stable payload while out_stall is high.
//   Configuration: cfg_we/cfg_index/cfg_data write a register at any edge;
//   every write also clears integrator, last measurement, history and the
//   out-of-band timer. Write only while no step is in flight.
// Sequence:
//   out_valid rises once the shift-add multiply has run five times (three
//   without derivative) and the restoring divide twice (once), followed by the
//   combine state; the derivative is skipped on the first step or with zero
//   elapsed time. Q16 scaling is a shift. A new input is taken the cycle
//   after the result is transferred.
// Reset:
//   rst_n (asynchronous, active low) loads register reset values, clears the
//   state and leaves both channels idle.
`default_nettype none
module pid_step_antiwindup_divergence
    import pid_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] target,
    input  wire logic signed [31:0] sensed,
    input  wire logic [15:0]        elapsed_ms,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      drive,
    output logic                    at_limit,
    output logic                    diverging
);
    typedef enum logic [4:0] {
        S_IDLE, S_P_MUL, S_P_DIV, S_I_MUL, S_I_DIV, S_I_MS, S_I_DIV2,
        S_D_MUL, S_D_DIV, S_D_GMUL, S_D_GDIV, S_COMB, S_OUT
    } state_t;

    localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] I32_MIN = -64'sd2147483648;

    state_t state_reg;
    logic signed [31:0] gp_reg, gi_reg, gd_reg, if_reg, ic_reg, df_reg, dc_reg;
    logic [30:0] band_reg;
    logic signed [31:0] integ_reg, last_reg;
    logic        hist_reg;
    logic [15:0] oob_reg;
    logic signed [32:0] err_reg;
    logic signed [31:0] sens_reg;
    logic [15:0] ms_reg;
    logic signed [63:0] p_reg, d_reg, si_reg;
    logic signed [31:0] drive_reg;
    logic        lim_reg, div_reg, out_valid_reg;

    unit_req_t   mreq, dreq;
    logic signed [63:0] ma, dnum, mprod, dquo;
    logic signed [32:0] mb;
    logic [15:0] dden;
    logic        mdone, ddone;

    pid_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .a(ma), .b(mb),
                   .done(mdone), .prod(mprod));
    pid_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .num(dnum), .den(dden),
                   .done(ddone), .quo(dquo));

    logic signed [32:0] err_w;
    logic signed [31:0] errs;
    logic signed [63:0] cand_raw, cand, u_c, u_h, u, drv;
    logic               hold;
    logic [32:0]        mag;
    logic [16:0]        oob_sum;
    logic [15:0]        oob_new;
    logic signed [63:0] rate;
    logic signed [32:0] dsens;

    assign err_w = 33'(target) - 33'(sensed);
    assign errs  = (err_reg > 33'sd2147483647) ? 32'h7fffffff :
                   (err_reg < -33'sd2147483648) ? 32'h80000000 : err_reg[31:0];
    assign dsens = 33'(sens_reg) - 33'(last_reg);
    assign rate  = (dquo > I32_MAX) ? I32_MAX : (dquo < I32_MIN) ? I32_MIN : dquo;

    // Integrator candidate, hold test, drive clamp, error magnitude and out-of-band sum; clamps check the floor first.
    always_comb
    begin
        cand_raw = 64'(integ_reg) + si_reg;
        if (cand_raw < 64'(if_reg))
            cand = 64'(if_reg);
        else if (cand_raw > 64'(ic_reg))
            cand = 64'(ic_reg);
        else
            cand = cand_raw;
        u_c  = p_reg + cand + d_reg;
        u_h  = p_reg + 64'(integ_reg) + d_reg;
        hold = (u_c > 64'(dc_reg) && err_reg > 33'sd0) ||
               (u_c < 64'(df_reg) && err_reg < 33'sd0);
        u    = hold ? u_h : u_c;
        if (u < 64'(df_reg))
            drv = 64'(df_reg);
        else if (u > 64'(dc_reg))
            drv = 64'(dc_reg);
        else
            drv = u;
        mag     = err_reg[32] ? 33'(-err_reg) : 33'(err_reg);
        oob_sum = 17'(oob_reg) + 17'(ms_reg);
        oob_new = oob_sum[16] ? 16'hffff : oob_sum[15:0];
    end

    // Operand selection per sequencer step.
    always_comb
    begin
        ma   = mprod;
        mb   = '0;
        dnum = mprod;
        dden = 16'd1;
        unique case (state_reg)
            S_P_MUL:  ma = 64'(gp_reg);
            S_I_MUL:  ma = 64'(gi_reg);
            S_I_MS:   ma = si_reg;
            S_D_MUL:  ma = 64'(dsens);
            S_D_GMUL: ma = 64'(gd_reg);
            default:  ma = mprod;
        endcase
        unique case (state_reg)
            S_P_MUL, S_I_MUL: mb = 33'(errs);
            S_I_MS:           mb = 33'(ms_reg);
            S_D_MUL:          mb = 33'sd1000;
            S_D_GMUL:         mb = 33'(rate);
            default:          mb = '0;
        endcase
        unique case (state_reg)
            S_I_DIV2: dden = 16'd1000;
            S_D_DIV:  dden = ms_reg;
            default:  dden = 16'd1;
        endcase
        // Q16 scaling does not use the divider; it is the q16 shift, x/65536 truncating.
        dnum = mprod;
        if (state_reg == S_P_DIV || state_reg == S_I_DIV || state_reg == S_D_GDIV)
            dden = 16'd1;
    end

    // Divide by 65536 truncating toward zero via bias-and-shift.
    function automatic logic signed [63:0] q16(input logic signed [63:0] x);
        logic signed [63:0] b;
        b = x[63] ? x + 64'sd65535 : x;
        return b >>> 16;
    endfunction

    logic step_go;
    assign step_go = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gp_reg        <= '0;
            gi_reg        <= '0;
            gd_reg        <= '0;
            if_reg        <= -32'sd65536;
            ic_reg        <= 32'sd65536;
            df_reg        <= -32'sd65536;
            dc_reg        <= 32'sd65536;
            band_reg      <= 31'h7fffffff;
            integ_reg     <= '0;
            last_reg      <= '0;
            hist_reg      <= 1'b0;
            oob_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_GAIN_PROP:     gp_reg   <= cfg_data;
                    REG_GAIN_INTEG:    gi_reg   <= cfg_data;
                    REG_GAIN_DERIV:    gd_reg   <= cfg_data;
                    REG_INTEG_FLOOR:   if_reg   <= cfg_data;
                    REG_INTEG_CEILING: ic_reg   <= cfg_data;
                    REG_DRIVE_FLOOR:   df_reg   <= cfg_data;
                    REG_DRIVE_CEILING: dc_reg   <= cfg_data;
                    REG_ERROR_BAND:    band_reg <= cfg_data[30:0];
                    default:           band_reg <= band_reg;
                endcase
                integ_reg <= '0;
                last_reg  <= '0;
                hist_reg  <= 1'b0;
                oob_reg   <= '0;
            end
            unique case (state_reg)
                S_IDLE:
                    if (step_go)
                    begin
                        err_reg   <= err_w;
                        sens_reg  <= sensed;
                        ms_reg    <= elapsed_ms;
                        state_reg <= S_P_MUL;
                    end
                S_P_MUL:  state_reg <= S_P_DIV;
                S_P_DIV:
                    if (mdone)
                    begin
                        p_reg     <= q16(mprod);
                        state_reg <= S_I_MUL;
                    end
                S_I_MUL:  state_reg <= S_I_DIV;
                S_I_DIV:
                    if (mdone)
                    begin
                        si_reg    <= q16(mprod);
                        state_reg <= S_I_MS;
                    end
                S_I_MS:   state_reg <= S_I_DIV2;
                S_I_DIV2:
                    if (ddone)
                    begin
                        si_reg    <= dquo;
                        state_reg <= S_D_MUL;
                    end
                    else if (mdone)
                        state_reg <= S_I_DIV2;
                S_D_MUL:
                    if (!hist_reg || ms_reg == 16'd0)
                    begin
                        d_reg     <= '0;
                        state_reg <= S_COMB;
                    end
                    else
                        state_reg <= S_D_DIV;
                S_D_DIV:  if (ddone) state_reg <= S_D_GMUL;
                S_D_GMUL: state_reg <= S_D_GDIV;
                S_D_GDIV:
                    if (mdone)
                    begin
                        d_reg     <= -q16(mprod);
                        state_reg <= S_COMB;
                    end
                S_COMB:
                begin
                    if (!hold)
                        integ_reg <= cand[31:0];
                    drive_reg <= drv[31:0];
                    lim_reg   <= (drv != u);
                    if (mag > 33'(band_reg))
                    begin
                        oob_reg <= oob_new;
                        div_reg <= (oob_new >= 16'(DIVERGE_TIME_MS));
                    end
                    else
                    begin
                        oob_reg <= '0;
                        div_reg <= 1'b0;
                    end
                    last_reg      <= sens_reg;
                    hist_reg      <= 1'b1;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Unit starts are issued in the cycle each operand set is presented.
    always_comb
    begin
        mreq.start = (state_reg == S_P_MUL) || (state_reg == S_I_MUL) ||
                     (state_reg == S_I_MS) ||
                     (state_reg == S_D_MUL && hist_reg && ms_reg != 16'd0) ||
                     (state_reg == S_D_GMUL);
        dreq.start = (state_reg == S_I_DIV2 && mdone) ||
                     (state_reg == S_D_DIV && mdone);
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign at_limit  = lim_reg;
    assign diverging = div_reg;

    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == S_OUT)
        else $error("result shown outside output state");
    a_hist_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COMB && !cfg_we |=> hist_reg)
        else $error("history not set");
    a_no_start_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mreq.start && dreq.start && state_reg == S_P_MUL))
        else $error("unit start overlap");
endmodule
`default_nettype wire

### design/pid_mul.sv
// Shift-add multiplier: signed 64 x signed 33, one bit per cycle.
`default_nettype none
module pid_mul
    import pid_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire unit_req_t          req,
    input  wire logic signed [63:0] a,
    input  wire logic signed [32:0] b,
    output logic                    done,
    output logic signed [63:0]      prod
);
    logic [63:0] acc_reg, acc_next;
    logic [63:0] mcand_reg, mcand_next;
    logic [32:0] mplier_reg, mplier_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    // Magnitudes are multiplied bit-serially; the sign is applied at the end.
    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (req.start)
        begin
            acc_next    = '0;
            mcand_next  = a[63] ? 64'(-a) : 64'(a);
            mplier_next = b[32] ? 33'(-b) : 33'(b);
            neg_next    = a[63] ^ b[32];
            cnt_next    = 6'd33;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[62:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[32:1]};
            cnt_next    = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        neg_reg    <= neg_next;
    end

    assign done = done_reg;
    assign prod = neg_reg ? 64'(-acc_reg) : 64'(acc_reg);

    a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("mul done held");
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("mul busy after done");
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == 6'd0 || done_reg || $past(req.start) == 1'b0)
        else $error("mul count");
endmodule
`default_nettype wire

### design/pid_div.sv
// Restoring divider: signed 64 / unsigned 16, truncating, one quotient bit per cycle.
`default_nettype none
module pid_div
    import pid_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire unit_req_t          req,
    input  wire logic signed [63:0] num,
    input  wire logic [15:0]        den,
    output logic                    done,
    output logic signed [63:0]      quo
);
    logic [63:0] q_reg, q_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;
    logic [17:0] diff;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[15:0], q_reg[63]};
        diff      = {1'b0, trial} - {2'b00, den_reg};
        if (req.start)
        begin
            q_next    = num[63] ? 64'(-num) : 64'(num);
            rem_next  = '0;
            den_next  = den;
            neg_next  = num[63];
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[17])
            begin
                rem_next = diff[16:0];
                q_next   = {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? 64'(-q_reg) : 64'(q_reg);

    a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("div done held");
    a_rem_lt_den: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && den_reg != 16'd0 && !$past(req.start) |-> rem_reg < {1'b0, den_reg})
        else $error("div remainder");
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("div busy after done");
endmodule
`default_nettype wire

### sim/tb_pid_step_antiwindup_divergence.sv
// Testbench for the PID step block: directed and random steps against a local predictor.
`timescale 1ns / 100ps
module tb_pid_step_antiwindup_divergence
    import pid_pkg::*;
;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] target = '0;
    logic signed [31:0] sensed = '0;
    logic [15:0]        elapsed_ms = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] drive;
    logic               at_limit;
    logic               diverging;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               at_limit;
        logic               diverging;
    } pid_result_t;

    // predictor copy of registers and state
    longint kp, ki, kd, i_lo, i_hi, d_lo, d_hi, band;
    longint integ_acc, prev_sensed;
    bit     seen_step;
    int     oob_ms;

    pid_result_t expected_q[$];
    int     errors = 0;
    int     checked = 0;
    int     sent = 0;
    bit     long_stalls = 1'b0;

    pid_step_antiwindup_divergence dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #10000000;
        $display("FAIL pid_step_antiwindup_divergence");
        $finish;
    end

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    function automatic void clear_pid_state();
        integ_acc = 0;
        prev_sensed = 0;
        seen_step = 0;
        oob_ms = 0;
    endfunction

    function automatic pid_result_t predict_step(logic signed [31:0] t, logic signed [31:0] s,
                                                 logic [15:0] ms_in);
        longint err, errs, p, d, rate, step, cand, u, drv, mag, ms;
        bit hold;
        pid_result_t r;
        ms = ms_in;
        err = longint'(t) - longint'(s);
        errs = sat32(err);
        p = (kp * errs) / 65536;
        d = 0;
        if (seen_step && ms > 0)
        begin
            rate = sat32(((longint'(s) - prev_sensed) * 1000) / ms);
            d = -((kd * rate) / 65536);
        end
        step = (((ki * errs) / 65536) * ms) / 1000;
        cand = clip(integ_acc + step, i_lo, i_hi);
        u = p + cand + d;
        hold = (u > d_hi && err > 0) || (u < d_lo && err < 0);
        if (hold)
            u = p + integ_acc + d;
        else
            integ_acc = cand;
        drv = clip(u, d_lo, d_hi);
        mag = err < 0 ? -err : err;
        r.diverging = 1'b0;
        if (mag > band)
        begin
            oob_ms = oob_ms + int'(ms);
            if (oob_ms > 65535) oob_ms = 65535;
            r.diverging = (oob_ms >= DIVERGE_TIME_MS);
        end
        else
            oob_ms = 0;
        prev_sensed = s;
        seen_step = 1;
        r.drive = drv[31:0];
        r.at_limit = (drv != u);
        return r;
    endfunction

    task automatic random_gap(int pct);
        int n;
        if ($urandom_range(99) >= pct) return;
        n = ($urandom_range(9) == 0) ? $urandom_range(40, 400) : $urandom_range(1, 4);
        repeat (n) @(posedge clk);
    endtask

    task automatic send_step(logic signed [31:0] t, logic signed [31:0] s, logic [15:0] ms);
        random_gap(30);
        target     <= t;
        sensed     <= s;
        elapsed_ms <= ms;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_q.push_back(predict_step(t, s, ms));
        sent++;
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [31:0] val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_GAIN_PROP:     kp   = longint'(signed'(val));
            REG_GAIN_INTEG:    ki   = longint'(signed'(val));
            REG_GAIN_DERIV:    kd   = longint'(signed'(val));
            REG_INTEG_FLOOR:   i_lo = longint'(signed'(val));
            REG_INTEG_CEILING: i_hi = longint'(signed'(val));
            REG_DRIVE_FLOOR:   d_lo = longint'(signed'(val));
            REG_DRIVE_CEILING: d_hi = longint'(signed'(val));
            REG_ERROR_BAND:    band = longint'(val[30:0]);
            default: ;
        endcase
        clear_pid_state();
    endtask

    task automatic write_all(longint p, longint i, longint d, longint il, longint ih,
                             longint dl, longint dh, longint b);
        write_reg(REG_GAIN_PROP, p[31:0]);
        write_reg(REG_GAIN_INTEG, i[31:0]);
        write_reg(REG_GAIN_DERIV, d[31:0]);
        write_reg(REG_INTEG_FLOOR, il[31:0]);
        write_reg(REG_INTEG_CEILING, ih[31:0]);
        write_reg(REG_DRIVE_FLOOR, dl[31:0]);
        write_reg(REG_DRIVE_CEILING, dh[31:0]);
        write_reg(REG_ERROR_BAND, b[31:0]);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom();
        endcase
    endfunction

    // response checker
    always @(posedge clk)
    begin
        pid_result_t exp_r;
        if (out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result drive=%0d", drive);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                checked++;
                if (exp_r.drive !== drive || exp_r.at_limit !== at_limit ||
                    exp_r.diverging !== diverging)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch #%0d: exp drive=%0d lim=%b div=%b got %0d %b %b",
                                 checked, exp_r.drive, exp_r.at_limit, exp_r.diverging,
                                 drive, at_limit, diverging);
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (long_stalls && $urandom_range(99) < 2)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < (long_stalls ? 60 : 20));
    end

    task automatic test_reset_defaults();
        send_step(32'sh0001_0000, 32'sh0000_0000, 16'd10);
        send_step(32'sh7fff_ffff, 32'sh8000_0000, 16'd0);
        send_step(32'sh8000_0000, 32'sh7fff_ffff, 16'hffff);
    endtask

    task automatic test_directed_extremes();
        write_all(64'sh0001_0000, 64'sh0002_0000, 64'sh0000_8000, -64'sh0001_0000,
                  64'sh0001_0000, -64'sh0002_0000, 64'sh0002_0000, 64'sh0000_8000);
        send_step(32'sh0001_0000, 32'sh0000_0000, 16'd0);    // first step, no derivative
        send_step(32'sh0001_0000, 32'sh0000_4000, 16'd0);    // zero elapsed
        send_step(32'sh0010_0000, 32'sh0000_0000, 16'd500);  // drive saturates up, hold
        send_step(-32'sh0010_0000, 32'sh0000_0000, 16'd600); // saturates down
        send_step(32'sh7fff_ffff, 32'sh8000_0000, 16'hffff); // error beyond 32 bits
        send_step(32'sh8000_0000, 32'sh7fff_ffff, 16'hffff);
        send_step(32'sh0000_0000, 32'sh0000_0000, 16'd1);     // back in band
        write_all(64'sh7fff_ffff, 64'sh7fff_ffff, 64'sh7fff_ffff, 64'sh0001_0000,
                  -64'sh0001_0000, 64'sh0001_0000, -64'sh0001_0000, 64'sh0);
        // floor above ceiling
        send_step(32'sh0000_1000, 32'sh0000_0000, 16'd1);
        send_step(32'sh7fff_ffff, 32'sh8000_0000, 16'd1);
        send_step(32'sh8000_0000, 32'sh7fff_ffff, 16'd1);
        write_all(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
                  64'sh7fff_ffff, -64'sh8000_0000, 64'sh7fff_ffff, 64'sh7fff_ffff);
        send_step(32'sh7fff_ffff, 32'sh0000_0000, 16'd1);
        send_step(32'sh0000_0000, 32'sh7fff_ffff, 16'd1);
        send_step(32'sh0000_0000, 32'sh8000_0000, 16'hffff);
    endtask

    task automatic test_divergence_timer();
        write_all(64'sh0000_4000, 64'sh0000_1000, 64'sh0, -64'sh0004_0000,
                  64'sh0004_0000, -64'sh0004_0000, 64'sh0004_0000, 64'sh0001_0000);
        repeat (6) send_step(32'sh0003_0000, 32'sh0000_0000, 16'd250);
        send_step(32'sh0000_0000, 32'sh0000_0000, 16'd250);
        send_step(32'sh0003_0000, 32'sh0000_0000, 16'd999);
        send_step(32'sh0003_0000, 32'sh0000_0000, 16'd1);
    endtask

    task automatic test_random_steps(int count);
        int k;
        logic signed [31:0] s;
        for (k = 0; k < count; k++)
        begin
            if (k % 150 == 0)
            begin
                write_all($urandom_range(0, 32'h0004_0000) - 64'sh0002_0000,
                          $urandom_range(0, 32'h0010_0000) - 64'sh0008_0000,
                          $urandom_range(0, 32'h0000_4000) - 64'sh0000_2000,
                          -longint'($urandom_range(0, 32'h0008_0000)),
                          longint'($urandom_range(0, 32'h0008_0000)),
                          -longint'($urandom_range(0, 32'h0008_0000)),
                          longint'($urandom_range(0, 32'h0008_0000)),
                          longint'($urandom_range(0, 32'h0002_0000)));
                long_stalls = $urandom_range(1);
            end
            if (k % 300 == 299)
                write_reg(reg_index_t'($urandom_range(7)), rand_q());
            if ($urandom_range(9) == 0)
                send_step(rand_q(), rand_q(), 16'($urandom()));
            else
            begin
                s = $urandom_range(0, 32'h0008_0000) - 32'sh0004_0000;
                send_step(s + ($urandom_range(0, 32'h0006_0000) - 32'sh0003_0000), s,
                          16'($urandom_range(0, 400)));
            end
            if (k == count / 2) wait_drained();   // let everything in flight come out
        end
    endtask

    initial
    begin
        kp = 0; ki = 0; kd = 0;
        i_lo = -65536; i_hi = 65536; d_lo = -65536; d_hi = 65536;
        band = 64'sd2147483647;
        clear_pid_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_extremes();
        test_divergence_timer();
        test_random_steps(1150);
        wait_drained();
        repeat (500) @(posedge clk);
        $display("Sent %0d steps, checked %0d results over directed, divergence and random",
                 sent, checked);
        $display("phases; %0d mismatches, %0d results outstanding.", errors, expected_q.size());
        if (errors == 0 && expected_q.size() == 0)
            $display("PASS pid_step_antiwindup_divergence");
        else
            $display("FAIL pid_step_antiwindup_divergence");
        $finish;
    end
endmodule
